@@ hw/rtl/mqad_pkg.sv @@
// Shared types, constants and glyph lookup for the mouse arrow display.
`timescale 1ns / 1ps
`default_nettype none
package mqad_pkg;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_TICK   = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    GLYPH_UP    = 2'd0,
    GLYPH_RIGHT = 2'd1,
    GLYPH_DOWN  = 2'd2,
    GLYPH_LEFT  = 2'd3
  } glyph_e;

  typedef struct packed {
    logic sample;
    logic tick;
  } step_ctrl_t;

  localparam int unsigned PIN_BITS = 4;
  localparam int unsigned ROW_BITS = 3;
  localparam int unsigned PATTERN_BITS = 16;

  localparam logic [PIN_BITS-1:0] EDGE_MASK_RESET = 4'hF;
  localparam logic [PIN_BITS-1:0] CHANGE_X_ONLY = 4'b0001;
  localparam logic [PIN_BITS-1:0] CHANGE_Y_ONLY = 4'b0100;
  localparam int unsigned PIN_XB = 1;
  localparam int unsigned PIN_YB = 3;

  localparam logic [ROW_BITS-1:0] ROW_FIRST = 3'd0;
  localparam logic [ROW_BITS-1:0] ROW_LAST  = 3'd7;

  localparam logic [PATTERN_BITS-1:0] PAT_BLANK = 16'h0000;
  localparam logic [PATTERN_BITS-1:0] PAT_UP    = 16'h00FF;
  localparam logic [PATTERN_BITS-1:0] PAT_RIGHT = 16'h8080;
  localparam logic [PATTERN_BITS-1:0] PAT_DOWN  = 16'hFF00;
  localparam logic [PATTERN_BITS-1:0] PAT_LEFT  = 16'h0101;

  function automatic logic [PATTERN_BITS-1:0] glyph_row(glyph_e g, logic [ROW_BITS-1:0] row);
    logic [PATTERN_BITS-1:0] pat;
    pat = PAT_BLANK;
    case (g)
      GLYPH_UP: begin
        if (row == ROW_FIRST) pat = PAT_UP;
      end
      GLYPH_RIGHT: pat = PAT_RIGHT;
      GLYPH_DOWN: begin
        if (row == ROW_LAST) pat = PAT_DOWN;
      end
      GLYPH_LEFT: pat = PAT_LEFT;
      default: pat = PAT_BLANK;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mqad_if.sv @@
// Valid/ready channel interfaces for input items and row results.
`timescale 1ns / 1ps
`default_nettype none
interface mqad_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [3:0] pin_sample;

  modport source (output valid, output mode, output pin_sample, input ready);
  modport sink (input valid, input mode, input pin_sample, output ready);
endinterface

interface mqad_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] row_pattern;
  logic [2:0]  row_index;

  modport source (output valid, output row_pattern, output row_index, input ready);
  modport sink (input valid, input row_pattern, input row_index, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mqad_counter.sv @@
// Quadrature edge qualification and X/Y movement counters.
`timescale 1ns / 1ps
`default_nettype none
module mqad_counter
  import mqad_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire step_ctrl_t            ctrl_i,
  input  wire logic [PIN_BITS-1:0]   pins_i,
  input  wire logic                  edge_mask_we_i,
  input  wire logic [PIN_BITS-1:0]   edge_mask_i,
  input  wire logic                  clear_i,
  output logic [COUNT_BITS-1:0]      x_count_o,
  output logic [COUNT_BITS-1:0]      y_count_o,
  output logic                       moved_o
);

  logic [PIN_BITS-1:0]   edge_mask_q;
  logic [PIN_BITS-1:0]   prev_q, prev_d;
  logic [COUNT_BITS-1:0] x_q, x_d;
  logic [COUNT_BITS-1:0] y_q, y_d;
  logic                  moved_q, moved_d;
  logic [PIN_BITS-1:0]   change;

  assign change = (prev_q ^ pins_i) & (prev_q ^ edge_mask_q);

  always_comb begin
    prev_d  = prev_q;
    x_d     = x_q;
    y_d     = y_q;
    moved_d = moved_q;
    if (ctrl_i.sample) begin
      prev_d  = pins_i;
      moved_d = 1'b1;
      if (change == CHANGE_X_ONLY) begin
        x_d = pins_i[PIN_XB] ? x_q - COUNT_BITS'(1) : x_q + COUNT_BITS'(1);
      end
      if (change == CHANGE_Y_ONLY) begin
        y_d = pins_i[PIN_YB] ? y_q - COUNT_BITS'(1) : y_q + COUNT_BITS'(1);
      end
    end else if (clear_i) begin
      x_d     = '0;
      y_d     = '0;
      moved_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_mask_q <= EDGE_MASK_RESET;
      prev_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      moved_q     <= 1'b1;
    end else begin
      if (edge_mask_we_i) edge_mask_q <= edge_mask_i;
      prev_q  <= prev_d;
      x_q     <= x_d;
      y_q     <= y_d;
      moved_q <= moved_d;
    end
  end

  assign x_count_o = x_q;
  assign y_count_o = y_q;
  assign moved_o   = moved_q;

endmodule
`default_nettype wire

@@ hw/rtl/mqad_scan.sv @@
// Arrow glyph choice, row scan counter and result register.
`timescale 1ns / 1ps
`default_nettype none
module mqad_scan
  import mqad_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire step_ctrl_t              ctrl_i,
  input  wire logic [COUNT_BITS-1:0]   x_count_i,
  input  wire logic [COUNT_BITS-1:0]   y_count_i,
  input  wire logic                    moved_i,
  input  wire logic                    out_ready_i,
  output logic                         out_free_o,
  output logic                         clear_o,
  output logic                         out_valid_o,
  output logic [PATTERN_BITS-1:0]      row_pattern_o,
  output logic [ROW_BITS-1:0]          row_index_o
);

  glyph_e                  glyph_q, glyph_d, glyph_pick;
  logic [ROW_BITS-1:0]     row_q;
  logic                    out_valid_q, out_valid_d;
  logic [PATTERN_BITS-1:0] pattern_q;
  logic [ROW_BITS-1:0]     index_q;
  logic [COUNT_BITS-1:0]   x_mag, y_mag;
  logic                    x_neg, y_neg;

  assign x_neg = x_count_i[COUNT_BITS-1];
  assign y_neg = y_count_i[COUNT_BITS-1];
  assign x_mag = x_neg ? (~x_count_i + COUNT_BITS'(1)) : x_count_i;
  assign y_mag = y_neg ? (~y_count_i + COUNT_BITS'(1)) : y_count_i;

  always_comb begin
    if (x_mag > y_mag) begin
      glyph_pick = x_neg ? GLYPH_LEFT : GLYPH_RIGHT;
    end else begin
      glyph_pick = y_neg ? GLYPH_DOWN : GLYPH_UP;
    end
  end

  assign clear_o    = ctrl_i.tick && moved_i && (row_q == ROW_FIRST);
  assign glyph_d    = clear_o ? glyph_pick : glyph_q;
  assign out_free_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (ctrl_i.tick) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_q     <= GLYPH_UP;
      row_q       <= ROW_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (ctrl_i.tick) begin
        glyph_q <= glyph_d;
        row_q   <= row_q + ROW_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tick) begin
      pattern_q <= glyph_row(glyph_d, row_q);
      index_q   <= row_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_pattern_o = pattern_q;
  assign row_index_o   = index_q;

endmodule
`default_nettype wire

@@ hw/rtl/mouse_quadrature_arrow_display.sv @@
// Top level: input register, movement counters and arrow row scan.
//
//   channel   dir  handshake      payload
//   in_i      in   valid/ready    mode, pin_sample
//   out_o     out  valid/ready    row_pattern, row_index
//   edge_mask in   we only        edge_mask_i
//
// One item per cycle unless a tick stalls; an item is worked from the input register.
// A tick's row passes the input register, then the result register; a sample gives none.
// A tick waits in the input register only while the result register is full and unread.
// Reset clears counts, sets the moved flag, selects the up arrow and row 0.
`timescale 1ns / 1ps
`default_nettype none
module mouse_quadrature_arrow_display
  import mqad_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  mqad_in_if.sink                  in_i,
  mqad_out_if.source               out_o,
  input  wire logic                edge_mask_we_i,
  input  wire logic [PIN_BITS-1:0] edge_mask_i
);

  logic                  in_valid_q;
  logic                  in_mode_q;
  logic [PIN_BITS-1:0]   in_pins_q;
  logic                  out_free;
  logic                  stall;
  logic                  fire;
  step_ctrl_t            ctrl;
  logic                  clear;
  logic [COUNT_BITS-1:0] x_count, y_count;
  logic                  moved;

  assign stall = in_valid_q && (mode_e'(in_mode_q) == MODE_TICK) && !out_free;
  assign fire  = in_valid_q && !stall;
  assign ctrl.sample = fire && (mode_e'(in_mode_q) == MODE_SAMPLE);
  assign ctrl.tick   = fire && (mode_e'(in_mode_q) == MODE_TICK);
  assign in_i.ready  = !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!stall) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall && in_i.valid) begin
      in_mode_q <= in_i.mode;
      in_pins_q <= in_i.pin_sample;
    end
  end

  mqad_counter #(
    .COUNT_BITS(COUNT_BITS)
  ) u_counter (
    .clk_i,
    .rst_ni,
    .ctrl_i        (ctrl),
    .pins_i        (in_pins_q),
    .edge_mask_we_i,
    .edge_mask_i,
    .clear_i       (clear),
    .x_count_o     (x_count),
    .y_count_o     (y_count),
    .moved_o       (moved)
  );

  mqad_scan #(
    .COUNT_BITS(COUNT_BITS)
  ) u_scan (
    .clk_i,
    .rst_ni,
    .ctrl_i        (ctrl),
    .x_count_i     (x_count),
    .y_count_i     (y_count),
    .moved_i       (moved),
    .out_ready_i   (out_o.ready),
    .out_free_o    (out_free),
    .clear_o       (clear),
    .out_valid_o   (out_o.valid),
    .row_pattern_o (out_o.row_pattern),
    .row_index_o   (out_o.row_index)
  );

endmodule
`default_nettype wire

@@ hw/rtl/mqad_checker.sv @@
// Port-level checks for the mouse arrow display, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mqad_checker
  import mqad_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [PATTERN_BITS-1:0] row_pattern,
  input wire logic [ROW_BITS-1:0]     row_index
);

  logic [ROW_BITS-1:0] exp_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_row_q <= ROW_FIRST;
    end else if (out_valid && out_ready) begin
      exp_row_q <= exp_row_q + ROW_BITS'(1);
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(row_pattern) && $stable(row_index))
    else $error("result changed while stalled");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> row_index == exp_row_q)
    else $error("row index out of sequence");

  a_mid_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && row_index != ROW_FIRST && row_index != ROW_LAST |->
      row_pattern == PAT_BLANK || row_pattern == PAT_RIGHT || row_pattern == PAT_LEFT)
    else $error("bad pattern on middle row");

  a_end_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(row_index == ROW_FIRST && row_pattern == PAT_DOWN) &&
      !(row_index == ROW_LAST && row_pattern == PAT_UP))
    else $error("arrow bar on wrong row");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid)
    else $error("result valid out of reset");

endmodule

bind mouse_quadrature_arrow_display mqad_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .row_pattern (out_o.row_pattern),
  .row_index   (out_o.row_index)
);
`default_nettype wire
